### rtl/gtg_pkg.sv
// Package with widths, constants and the arctangent table of the go-to-goal controller.
`timescale 1ns / 1ps
package gtg_pkg;
  localparam int unsigned CordicStepsDefault = 16;
  localparam int unsigned MaxSteps = 24;
  localparam int unsigned PosW = 16;
  localparam int unsigned AngW = 15;
  localparam int unsigned DiffW = 17;
  localparam int unsigned SqW = 34;
  localparam int unsigned RootW = 17;
  localparam int unsigned CxW = 28;
  localparam int unsigned ZW = 20;
  localparam int unsigned CfgIdxW = 2;
  localparam logic [RootW-1:0] NearQ12 = 17'd410;
  localparam logic [AngW:0] TurnQ12 = 16'd819;
  localparam logic signed [ZW-1:0] HalfPiQ16 = 20'sd102944;

  localparam logic [CfgIdxW-1:0] RegTargetX = 2'd0;
  localparam logic [CfgIdxW-1:0] RegTargetY = 2'd1;
  localparam logic [CfgIdxW-1:0] RegGain = 2'd2;
  localparam logic [CfgIdxW-1:0] RegSpeedLimit = 2'd3;

  typedef struct packed {
    logic [PosW-1:0] goal_x;
    logic [PosW-1:0] goal_y;
    logic [PosW-1:0] gain;
    logic [PosW-1:0] speed_limit;
  } cfg_t;

  function automatic logic signed [ZW-1:0] atan_entry(input int unsigned i);
    logic signed [ZW-1:0] r;
    begin
      unique case (i)
        0: r = 20'sd51472;  1: r = 20'sd30386;  2: r = 20'sd16055;  3: r = 20'sd8150;
        4: r = 20'sd4091;   5: r = 20'sd2047;   6: r = 20'sd1024;   7: r = 20'sd512;
        8: r = 20'sd256;    9: r = 20'sd128;    10: r = 20'sd64;    11: r = 20'sd32;
        12: r = 20'sd16;    13: r = 20'sd8;     14: r = 20'sd4;     15: r = 20'sd2;
        16: r = 20'sd1;
        default: r = '0;
      endcase
      return r;
    end
  endfunction
endpackage

### rtl/gtg_if.sv
// Valid/ready stream interface used for pose samples and speed commands.
`timescale 1ns / 1ps
interface gtg_if #(parameter int unsigned W = 32);
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/go_to_goal_speed_controller_unit.sv
// Top level of the go-to-goal speed controller: a fully pipelined pose-to-command datapath.
//
// Usage: pose samples (x, y, heading) enter on pose_if as one transfer each; every
// sample yields exactly one speed command transfer on cmd_if, in order.
// Payload packing on pose_if.data: [46:31] pose_x, [30:15] pose_y, [14:0] pose_heading.
// Payload packing on cmd_if.data: [30:15] linear_speed, [14:0] angular_speed.
// Configuration registers (goal x, goal y, gain, speed limit) are written
// through cfg_we_i/cfg_idx_i/cfg_data_i while the block is idle.
// There are CordicSteps + 4 register stages: one for the differences, one for
// squares and the CORDIC quadrant fold, one per CORDIC micro-rotation (the
// integer root runs alongside, two result bits per stage at the default), one for
// the gain multiply and one for the decision and output register.
// Throughput is one sample per cycle while the receiver does not stall; the pipeline length is
// set by the CORDIC micro-rotation count, and the 17 root bits are folded into those stages.
// When the receiver stalls, the whole pipeline holds with its valid bits, so no
// sample is lost or repeated; a stage with no valid item still accepts new data.
// Reset clears all valid bits and loads the configuration registers with their defaults.
`timescale 1ns / 1ps
module go_to_goal_speed_controller_unit #(
  parameter int unsigned CordicSteps = gtg_pkg::CordicStepsDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic [gtg_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [gtg_pkg::PosW-1:0] cfg_data_i,
  gtg_if.sink   pose_if,
  gtg_if.source cmd_if
);
  localparam int unsigned RootBits = gtg_pkg::RootW;
  // Root bits are computed over the CORDIC stages; several bits per stage when needed.
  localparam int unsigned BitsPerStage = (RootBits + CordicSteps - 1) / CordicSteps;
  localparam int unsigned NStages = CordicSteps + 4;

  gtg_pkg::cfg_t cfg_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.goal_x <= 16'd4096;
      cfg_q.goal_y <= 16'd4096;
      cfg_q.gain <= 16'd4096;
      cfg_q.speed_limit <= 16'd8192;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        gtg_pkg::RegTargetX: cfg_q.goal_x <= cfg_data_i;
        gtg_pkg::RegTargetY: cfg_q.goal_y <= cfg_data_i;
        gtg_pkg::RegGain: cfg_q.gain <= cfg_data_i;
        gtg_pkg::RegSpeedLimit: cfg_q.speed_limit <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Valid chain and global advance: a stage moves when the next one can take it.
  logic [NStages-1:0] vld_q;
  logic [NStages-1:0] adv;
  always_comb begin
    adv[NStages-1] = !vld_q[NStages-1] || cmd_if.ready;
    for (int s = NStages - 2; s >= 0; s--) adv[s] = !vld_q[s] || adv[s+1];
  end
  assign pose_if.ready = adv[0];
  assign cmd_if.valid = vld_q[NStages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else begin
      if (adv[0]) vld_q[0] <= pose_if.valid;
      for (int s = 1; s < NStages; s++) if (adv[s]) vld_q[s] <= vld_q[s-1];
    end
  end

  // Stage 0: differences and heading.
  logic signed [gtg_pkg::DiffW-1:0] dx_q, dy_q;
  logic signed [gtg_pkg::AngW-1:0] hd0_q;
  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      dx_q <= $signed({1'b0, cfg_q.goal_x}) - $signed({1'b0, pose_if.data[46:31]});
      dy_q <= $signed({1'b0, cfg_q.goal_y}) - $signed({1'b0, pose_if.data[30:15]});
      hd0_q <= $signed(pose_if.data[14:0]);
    end
  end

  // Stage 1: sum of squares and quadrant fold.
  logic [gtg_pkg::SqW-1:0] sq1_q;
  logic signed [gtg_pkg::CxW-1:0] cx1_q, cy1_q;
  logic signed [gtg_pkg::ZW-1:0] cz1_q;
  logic signed [gtg_pkg::AngW-1:0] hd1_q;
  logic signed [gtg_pkg::CxW-1:0] xe, ye;
  logic [2*gtg_pkg::DiffW-1:0] sqx, sqy;
  always_comb begin
    sqx = $unsigned((2*gtg_pkg::DiffW)'(dx_q) * (2*gtg_pkg::DiffW)'(dx_q));
    sqy = $unsigned((2*gtg_pkg::DiffW)'(dy_q) * (2*gtg_pkg::DiffW)'(dy_q));
    xe = gtg_pkg::CxW'(dx_q) <<< 8;
    ye = gtg_pkg::CxW'(dy_q) <<< 8;
  end
  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      sq1_q <= {1'b0, sqx[2*gtg_pkg::DiffW-2:0]} + {1'b0, sqy[2*gtg_pkg::DiffW-2:0]};
      hd1_q <= hd0_q;
      if (xe < 0 && ye >= 0) begin
        cx1_q <= ye; cy1_q <= -xe; cz1_q <= gtg_pkg::HalfPiQ16;
      end else if (xe < 0) begin
        cx1_q <= -ye; cy1_q <= xe; cz1_q <= -gtg_pkg::HalfPiQ16;
      end else begin
        cx1_q <= xe; cy1_q <= ye; cz1_q <= '0;
      end
    end
  end

  // CORDIC stages with the root computed alongside.
  logic signed [gtg_pkg::CxW-1:0] cx_q [CordicSteps+1];
  logic signed [gtg_pkg::CxW-1:0] cy_q [CordicSteps+1];
  logic signed [gtg_pkg::ZW-1:0] cz_q [CordicSteps+1];
  logic [gtg_pkg::SqW-1:0] rem_q [CordicSteps+1];
  logic [RootBits-1:0] root_q [CordicSteps+1];
  logic signed [gtg_pkg::AngW-1:0] hd_q [CordicSteps+1];
  assign cx_q[0] = cx1_q;
  assign cy_q[0] = cy1_q;
  assign cz_q[0] = cz1_q;
  assign rem_q[0] = sq1_q;
  assign root_q[0] = '0;
  assign hd_q[0] = hd1_q;

  for (genvar k = 0; k < CordicSteps; k++) begin : g_stage
    logic signed [gtg_pkg::CxW-1:0] xn, yn;
    logic signed [gtg_pkg::ZW-1:0] zn;
    logic [gtg_pkg::SqW-1:0] rems [BitsPerStage+1];
    logic [RootBits-1:0] roots [BitsPerStage+1];
    logic signed [gtg_pkg::CxW-1:0] xr_q, yr_q;
    logic signed [gtg_pkg::ZW-1:0] zr_q;
    logic [gtg_pkg::SqW-1:0] remr_q;
    logic [RootBits-1:0] rootr_q;
    logic signed [gtg_pkg::AngW-1:0] hdr_q;
    gtg_cordic_stage #(.Step(k)) u_cordic (
      .x_i(cx_q[k]), .y_i(cy_q[k]), .z_i(cz_q[k]), .x_o(xn), .y_o(yn), .z_o(zn)
    );
    assign rems[0] = rem_q[k];
    assign roots[0] = root_q[k];
    for (genvar b = 0; b < BitsPerStage; b++) begin : g_bit
      localparam int Idx = k * BitsPerStage + b;
      if (Idx < RootBits) begin : g_on
        gtg_sqrt_stage #(.Bit(RootBits - 1 - Idx)) u_sqrt (
          .rem_i(rems[b]), .root_i(roots[b]), .rem_o(rems[b+1]), .root_o(roots[b+1])
        );
      end else begin : g_off
        assign rems[b+1] = rems[b];
        assign roots[b+1] = roots[b];
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv[k+2]) begin
        xr_q <= xn; yr_q <= yn; zr_q <= zn;
        remr_q <= rems[BitsPerStage]; rootr_q <= roots[BitsPerStage];
        hdr_q <= hd_q[k];
      end
    end
    assign cx_q[k+1] = xr_q; assign cy_q[k+1] = yr_q; assign cz_q[k+1] = zr_q;
    assign rem_q[k+1] = remr_q; assign root_q[k+1] = rootr_q; assign hd_q[k+1] = hdr_q;
  end

  // Multiply stage: gain times distance, and the absolute angle error.
  logic [RootBits-1:0] dist_m_q;
  logic [gtg_pkg::PosW+RootBits-1:0] prod_q;
  logic [gtg_pkg::AngW:0] aerr_q;
  logic signed [gtg_pkg::ZW-1:0] bearing;
  logic signed [gtg_pkg::ZW-1:0] err;
  always_comb begin
    bearing = (cz_q[CordicSteps] + gtg_pkg::ZW'(8)) >>> 4;
    err = bearing - gtg_pkg::ZW'(hd_q[CordicSteps]);
  end
  always_ff @(posedge clk_i) begin
    if (adv[NStages-2]) begin
      dist_m_q <= root_q[CordicSteps];
      prod_q <= cfg_q.gain * root_q[CordicSteps];
      aerr_q <= err[gtg_pkg::ZW-1] ? (gtg_pkg::AngW+1)'(-err) : (gtg_pkg::AngW+1)'(err);
    end
  end

  // Decision and output register.
  logic [gtg_pkg::PosW-1:0] lin_q;
  logic [gtg_pkg::AngW-1:0] ang_q;
  logic [gtg_pkg::PosW+RootBits-13:0] lin_full;
  assign lin_full = prod_q[gtg_pkg::PosW+RootBits-1:12];
  always_ff @(posedge clk_i) begin
    if (adv[NStages-1]) begin
      if (dist_m_q <= gtg_pkg::NearQ12) begin
        lin_q <= '0; ang_q <= '0;
      end else if (aerr_q > gtg_pkg::TurnQ12) begin
        lin_q <= '0; ang_q <= aerr_q[gtg_pkg::AngW-1:0];
      end else begin
        ang_q <= '0;
        lin_q <= (lin_full > {5'd0, cfg_q.speed_limit}) ? cfg_q.speed_limit
                                                       : lin_full[gtg_pkg::PosW-1:0];
      end
    end
  end
  assign cmd_if.data = {lin_q, ang_q};
endmodule

### rtl/gtg_sqrt_stage.sv
// One stage of a pipelined restoring integer square root: one result bit per stage.
`timescale 1ns / 1ps
module gtg_sqrt_stage #(
  parameter int unsigned Bit = 0
) (
  input  logic [gtg_pkg::SqW-1:0]   rem_i,
  input  logic [gtg_pkg::RootW-1:0] root_i,
  output logic [gtg_pkg::SqW-1:0]   rem_o,
  output logic [gtg_pkg::RootW-1:0] root_o
);
  logic [gtg_pkg::SqW-1:0] trial;
  always_comb begin
    // Candidate (2*root + 2^Bit) * 2^Bit with root holding the bits found so far.
    trial = ({{(gtg_pkg::SqW-gtg_pkg::RootW){1'b0}}, root_i} << (Bit + 1))
          + ({{(gtg_pkg::SqW-1){1'b0}}, 1'b1} << (2 * Bit));
    if (rem_i >= trial) begin
      rem_o  = rem_i - trial;
      root_o = root_i | ({{(gtg_pkg::RootW-1){1'b0}}, 1'b1} << Bit);
    end else begin
      rem_o  = rem_i;
      root_o = root_i;
    end
  end
endmodule

### rtl/gtg_cordic_stage.sv
// One micro-rotation of the vectoring CORDIC used for the bearing.
`timescale 1ns / 1ps
module gtg_cordic_stage #(
  parameter int unsigned Step = 0
) (
  input  logic signed [gtg_pkg::CxW-1:0] x_i,
  input  logic signed [gtg_pkg::CxW-1:0] y_i,
  input  logic signed [gtg_pkg::ZW-1:0]  z_i,
  output logic signed [gtg_pkg::CxW-1:0] x_o,
  output logic signed [gtg_pkg::CxW-1:0] y_o,
  output logic signed [gtg_pkg::ZW-1:0]  z_o
);
  logic signed [gtg_pkg::CxW-1:0] xs, ys;
  always_comb begin
    xs = x_i >>> Step;
    ys = y_i >>> Step;
    if (y_i > 0) begin
      x_o = x_i + ys;
      y_o = y_i - xs;
      z_o = z_i + gtg_pkg::atan_entry(Step);
    end else begin
      x_o = x_i - ys;
      y_o = y_i + xs;
      z_o = z_i - gtg_pkg::atan_entry(Step);
    end
  end
endmodule
